[sv/timed_actuator_sequencer_unit_assert.svh]
// Assertion macros shared by the timed actuator sequencer RTL.
`ifndef TIMED_ACTUATOR_SEQUENCER_UNIT_ASSERT_SVH
`define TIMED_ACTUATOR_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TAS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tas_pkg.sv]
// Types, constants and sequence tables of the timed actuator sequencer.
`timescale 1ns / 1ps

package tas_pkg;

  // Delay counters and configuration registers
  localparam int unsigned DelayWidth = 16;
  localparam int unsigned StepWidth  = 4;
  localparam int unsigned MaxSeqLen  = 10;

  // Configuration register indexes
  localparam int unsigned CfgIdxWidth = 3;
  localparam logic [CfgIdxWidth-1:0] CfgSolenoidDelay = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgLiftDelay     = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgSettleDelay   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgGateDelay     = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgEndDelay      = 3'd4;

  // Reset values of the configuration registers
  localparam logic [DelayWidth-1:0] RstSolenoidDelay = 16'd300;
  localparam logic [DelayWidth-1:0] RstLiftDelay     = 16'd800;
  localparam logic [DelayWidth-1:0] RstSettleDelay   = 16'd50;
  localparam logic [DelayWidth-1:0] RstGateDelay     = 16'd30;
  localparam logic [DelayWidth-1:0] RstEndDelay      = 16'd100;

  // Mode codes
  typedef enum logic [2:0] {
    ModeNone        = 3'd0,
    ModeLarge       = 3'd1,
    ModeSmall       = 3'd2,
    ModeMidairReady = 3'd3,
    ModeMidairGet   = 3'd4,
    ModeExchange    = 3'd5,
    ModeReset       = 3'd6,
    ModeLaser       = 3'd7
  } mode_e;

  // End status codes
  localparam logic [1:0] EndRunning = 2'd0;
  localparam logic [1:0] EndDone    = 2'd1;
  localparam logic [1:0] EndMidair  = 2'd2;

  typedef enum logic [1:0] {
    OpSet  = 2'd0,
    OpGate = 2'd1,
    OpEnd  = 2'd2,
    OpHold = 2'd3
  } op_kind_e;

  typedef enum logic [2:0] {
    ActClamp   = 3'd0,
    ActForward = 3'd1,
    ActCatch   = 3'd2,
    ActLiftA   = 3'd3,
    ActLiftB   = 3'd4
  } act_e;

  typedef enum logic {
    DlySolenoid = 1'b0,
    DlyLift     = 1'b1
  } dly_e;

  typedef struct packed {
    op_kind_e   kind;
    act_e       act;
    logic [1:0] tgt;
    dly_e       dly;
  } seq_op_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       photogate;
    logic       ack_end;
  } in_item_t;

  typedef struct packed {
    logic                 clamp_on;
    logic                 arm_forward;
    logic                 catch_on;
    logic [1:0]           lift_first;
    logic [1:0]           lift_second;
    logic [1:0]           end_status;
    logic [StepWidth-1:0] step_now;
    logic                 waiting;
  } out_item_t;

  function automatic seq_op_t mk_op(op_kind_e kind, act_e act, logic [1:0] tgt, dly_e dly);
    seq_op_t op;
    op.kind = kind;
    op.act  = act;
    op.tgt  = tgt;
    op.dly  = dly;
    return op;
  endfunction

  // Number of steps in each mode's sequence
  function automatic logic [StepWidth-1:0] seq_len(mode_e mode);
    logic [StepWidth-1:0] len;
    case (mode)
      ModeLarge:       len = 4'd8;
      ModeSmall:       len = 4'd10;
      ModeMidairReady: len = 4'd6;
      ModeMidairGet:   len = 4'd6;
      ModeExchange:    len = 4'd5;
      ModeReset:       len = 4'd5;
      ModeLaser:       len = 4'd5;
      default:         len = 4'd0;
    endcase
    return len;
  endfunction

  // Operation at position idx (from 0) of a mode's sequence
  function automatic seq_op_t seq_op(mode_e mode, logic [StepWidth-1:0] idx);
    seq_op_t op;
    op = mk_op(OpEnd, ActClamp, 2'd0, DlySolenoid);
    case (mode)
      ModeLarge: begin
        case (idx)
          4'd0: op = mk_op(OpSet, ActClamp,   2'd0, DlySolenoid);
          4'd1: op = mk_op(OpSet, ActLiftA,   2'd2, DlyLift);
          4'd2: op = mk_op(OpSet, ActForward, 2'd1, DlySolenoid);
          4'd3: op = mk_op(OpSet, ActClamp,   2'd1, DlySolenoid);
          4'd4: op = mk_op(OpSet, ActLiftB,   2'd1, DlyLift);
          4'd5: op = mk_op(OpSet, ActForward, 2'd0, DlySolenoid);
          4'd6: op = mk_op(OpSet, ActLiftA,   2'd0, DlyLift);
          default: op = mk_op(OpEnd, ActClamp, 2'd0, DlySolenoid);
        endcase
      end
      ModeSmall: begin
        case (idx)
          4'd0: op = mk_op(OpSet, ActClamp,   2'd0, DlySolenoid);
          4'd1: op = mk_op(OpSet, ActLiftB,   2'd1, DlyLift);
          4'd2: op = mk_op(OpSet, ActLiftA,   2'd1, DlyLift);
          4'd3: op = mk_op(OpSet, ActForward, 2'd1, DlySolenoid);
          4'd4: op = mk_op(OpSet, ActClamp,   2'd1, DlySolenoid);
          4'd5: op = mk_op(OpSet, ActCatch,   2'd1, DlySolenoid);
          4'd6: op = mk_op(OpSet, ActLiftA,   2'd0, DlyLift);
          4'd7: op = mk_op(OpSet, ActForward, 2'd0, DlySolenoid);
          4'd8: op = mk_op(OpSet, ActCatch,   2'd0, DlySolenoid);
          default: op = mk_op(OpEnd, ActClamp, 2'd0, DlySolenoid);
        endcase
      end
      ModeMidairReady: begin
        case (idx)
          4'd0: op = mk_op(OpSet, ActClamp,   2'd0, DlySolenoid);
          4'd1: op = mk_op(OpSet, ActLiftB,   2'd1, DlyLift);
          4'd2: op = mk_op(OpSet, ActLiftA,   2'd2, DlyLift);
          4'd3: op = mk_op(OpSet, ActForward, 2'd1, DlySolenoid);
          4'd4: op = mk_op(OpSet, ActCatch,   2'd1, DlySolenoid);
          default: op = mk_op(OpHold, ActClamp, 2'd0, DlySolenoid);
        endcase
      end
      ModeMidairGet: begin
        case (idx)
          4'd0: op = mk_op(OpGate, ActClamp,   2'd0, DlySolenoid);
          4'd1: op = mk_op(OpSet,  ActClamp,   2'd1, DlySolenoid);
          4'd2: op = mk_op(OpSet,  ActForward, 2'd0, DlySolenoid);
          4'd3: op = mk_op(OpSet,  ActLiftA,   2'd0, DlyLift);
          4'd4: op = mk_op(OpSet,  ActCatch,   2'd0, DlySolenoid);
          default: op = mk_op(OpEnd, ActClamp, 2'd0, DlySolenoid);
        endcase
      end
      ModeExchange: begin
        case (idx)
          4'd0: op = mk_op(OpSet, ActClamp,   2'd1, DlySolenoid);
          4'd1: op = mk_op(OpSet, ActLiftB,   2'd2, DlyLift);
          4'd2: op = mk_op(OpSet, ActLiftA,   2'd1, DlyLift);
          4'd3: op = mk_op(OpSet, ActForward, 2'd1, DlySolenoid);
          default: op = mk_op(OpEnd, ActClamp, 2'd0, DlySolenoid);
        endcase
      end
      ModeReset: begin
        case (idx)
          4'd0: op = mk_op(OpSet, ActForward, 2'd0, DlySolenoid);
          4'd1: op = mk_op(OpSet, ActLiftA,   2'd0, DlyLift);
          4'd2: op = mk_op(OpSet, ActCatch,   2'd0, DlySolenoid);
          4'd3: op = mk_op(OpSet, ActLiftB,   2'd0, DlyLift);
          default: op = mk_op(OpEnd, ActClamp, 2'd0, DlySolenoid);
        endcase
      end
      ModeLaser: begin
        // Laser clamp close waits the lift delay
        case (idx)
          4'd0: op = mk_op(OpSet, ActClamp,   2'd0, DlySolenoid);
          4'd1: op = mk_op(OpSet, ActLiftA,   2'd2, DlyLift);
          4'd2: op = mk_op(OpSet, ActForward, 2'd1, DlySolenoid);
          4'd3: op = mk_op(OpSet, ActClamp,   2'd1, DlyLift);
          default: op = mk_op(OpEnd, ActClamp, 2'd0, DlySolenoid);
        endcase
      end
      default: op = mk_op(OpEnd, ActClamp, 2'd0, DlySolenoid);
    endcase
    return op;
  endfunction

endpackage

[sv/timed_actuator_sequencer_unit.sv]
// Top level of the timed actuator sequencer: step state, delay timer and result register.
`timescale 1ns / 1ps
`include "timed_actuator_sequencer_unit_assert.svh"

// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one beat per millisecond
//   tick, carrying mode, photogate level and end acknowledge.
//   Output channel (out_valid_o / out_stall_i / out_data_o): one beat per input
//   beat, holding solenoid commands, lift positions, end status, step and wait flag.
//   Configuration port (cfg_we_i / cfg_idx_i / cfg_data_i): writes the five delay
//   registers in ticks; indexes past the end delay are ignored.
//   A result appears in the cycle after its tick is taken. Throughput: one tick per
//   cycle unless the receiver stalls; the whole update is one pass from the state
//   registers through the sequence table and timer compare into the result register.
//   Stall: the result register holds while the receiver stalls; the input is
//   stalled only while a result waits and the receiver stalls, so a new tick is
//   taken in the same cycle as the waiting result leaves.
//   Reset: all actuators off and lowered, sequence idle, no wait running, end
//   status clear, delay registers at their default values, output empty.
module timed_actuator_sequencer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tas_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tas_pkg::out_item_t                 out_data_o,
  input  logic                               cfg_we_i,
  input  logic [tas_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [tas_pkg::DelayWidth-1:0]     cfg_data_i
);

  localparam int unsigned DW = tas_pkg::DelayWidth;
  localparam int unsigned SW = tas_pkg::StepWidth;

  // Configuration registers
  logic [DW-1:0] sol_dly_q, lift_dly_q, settle_dly_q, gate_dly_q, end_dly_q;

  // Sequencer state
  logic [SW-1:0] step_q, step_d;
  logic [SW-1:0] next_step_q, next_step_d;
  logic          wait_active_q, wait_active_d;
  logic [DW-1:0] wait_elapsed_q, wait_elapsed_d;
  logic [DW-1:0] wait_length_q, wait_length_d;
  logic [2:0]    prev_mode_q;
  logic          clamp_q, clamp_d;
  logic          forward_q, forward_d;
  logic          catch_q, catch_d;
  logic [1:0]    lift_a_q, lift_a_d;
  logic [1:0]    lift_b_q, lift_b_d;
  logic [1:0]    end_q, end_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  tas_pkg::out_item_t out_data_q, out_data_d;

  logic in_accept;

  // Intermediate values of the tick update
  tas_pkg::mode_e    mode;
  tas_pkg::seq_op_t  op;
  logic [SW-1:0]     len;
  logic [SW-1:0]     cur_step;
  logic [1:0]        act_val;
  logic              do_wait;
  logic [DW-1:0]     wait_len;
  logic [DW-1:0]     elapsed_inc;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Write the delay registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sol_dly_q    <= tas_pkg::RstSolenoidDelay;
      lift_dly_q   <= tas_pkg::RstLiftDelay;
      settle_dly_q <= tas_pkg::RstSettleDelay;
      gate_dly_q   <= tas_pkg::RstGateDelay;
      end_dly_q    <= tas_pkg::RstEndDelay;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tas_pkg::CfgSolenoidDelay: sol_dly_q    <= cfg_data_i;
        tas_pkg::CfgLiftDelay:     lift_dly_q   <= cfg_data_i;
        tas_pkg::CfgSettleDelay:   settle_dly_q <= cfg_data_i;
        tas_pkg::CfgGateDelay:     gate_dly_q   <= cfg_data_i;
        tas_pkg::CfgEndDelay:      end_dly_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the sequencer by one tick
  always_comb begin
    mode           = tas_pkg::mode_e'(in_data_i.mode);
    end_d          = in_data_i.ack_end ? tas_pkg::EndRunning : end_q;
    step_d         = step_q;
    next_step_d    = next_step_q;
    wait_active_d  = wait_active_q;
    wait_elapsed_d = wait_elapsed_q;
    wait_length_d  = wait_length_q;
    clamp_d        = clamp_q;
    forward_d      = forward_q;
    catch_d        = catch_q;
    lift_a_d       = lift_a_q;
    lift_b_d       = lift_b_q;
    do_wait        = 1'b0;
    wait_len       = settle_dly_q;
    act_val        = 2'd0;

    // Count the running wait and leave the step when it expires
    elapsed_inc = (wait_elapsed_q == {DW{1'b1}}) ? wait_elapsed_q : wait_elapsed_q + 1'b1;
    if (wait_active_q) begin
      wait_elapsed_d = elapsed_inc;
      if (elapsed_inc >= wait_length_q) begin
        step_d        = next_step_q;
        wait_active_d = 1'b0;
      end
    end

    // Drop to idle on a mode change
    if (prev_mode_q != in_data_i.mode) begin
      step_d      = '0;
      next_step_d = '0;
    end

    cur_step = step_d;
    len      = tas_pkg::seq_len(mode);
    op       = tas_pkg::seq_op(mode, cur_step - 1'b1);

    case (op.act)
      tas_pkg::ActClamp:   act_val = {1'b0, clamp_q};
      tas_pkg::ActForward: act_val = {1'b0, forward_q};
      tas_pkg::ActCatch:   act_val = {1'b0, catch_q};
      tas_pkg::ActLiftA:   act_val = lift_a_q;
      default:             act_val = lift_b_q;
    endcase

    // Run the current step
    if (mode != tas_pkg::ModeNone) begin
      if (cur_step == '0) begin
        step_d      = SW'(1);
        next_step_d = SW'(1);
      end else if (cur_step > len) begin
        step_d      = '0;
        next_step_d = '0;
      end else begin
        case (op.kind)
          tas_pkg::OpSet: begin
            next_step_d = cur_step + 1'b1;
            do_wait     = 1'b1;
            if (act_val != op.tgt) begin
              wait_len = (op.dly == tas_pkg::DlyLift) ? lift_dly_q : sol_dly_q;
              case (op.act)
                tas_pkg::ActClamp:   clamp_d   = op.tgt[0];
                tas_pkg::ActForward: forward_d = op.tgt[0];
                tas_pkg::ActCatch:   catch_d   = op.tgt[0];
                tas_pkg::ActLiftA:   lift_a_d  = op.tgt;
                default:             lift_b_d  = op.tgt;
              endcase
            end else begin
              wait_len = settle_dly_q;
            end
          end
          tas_pkg::OpGate: begin
            next_step_d = cur_step + 1'b1;
            do_wait     = in_data_i.photogate;
            wait_len    = gate_dly_q;
          end
          tas_pkg::OpEnd: begin
            next_step_d = '0;
            end_d       = tas_pkg::EndDone;
            do_wait     = 1'b1;
            wait_len    = end_dly_q;
          end
          default: begin
            next_step_d = '0;
            end_d       = tas_pkg::EndMidair;
          end
        endcase
      end
    end

    // Start a wait only when none is running
    if (do_wait && !wait_active_d) begin
      wait_active_d  = 1'b1;
      wait_length_d  = wait_len;
      wait_elapsed_d = '0;
    end

    out_data_d.clamp_on    = clamp_d;
    out_data_d.arm_forward = forward_d;
    out_data_d.catch_on    = catch_d;
    out_data_d.lift_first  = lift_a_d;
    out_data_d.lift_second = lift_b_d;
    out_data_d.end_status  = end_d;
    out_data_d.step_now    = step_d;
    out_data_d.waiting     = wait_active_d;
  end

  // Hold the state until a tick is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= '0;
      next_step_q    <= '0;
      wait_active_q  <= 1'b0;
      wait_elapsed_q <= '0;
      wait_length_q  <= '0;
      prev_mode_q    <= tas_pkg::ModeNone;
      clamp_q        <= 1'b0;
      forward_q      <= 1'b0;
      catch_q        <= 1'b0;
      lift_a_q       <= 2'd0;
      lift_b_q       <= 2'd0;
      end_q          <= tas_pkg::EndRunning;
    end else if (in_accept) begin
      step_q         <= step_d;
      next_step_q    <= next_step_d;
      wait_active_q  <= wait_active_d;
      wait_elapsed_q <= wait_elapsed_d;
      wait_length_q  <= wait_length_d;
      prev_mode_q    <= in_data_i.mode;
      clamp_q        <= clamp_d;
      forward_q      <= forward_d;
      catch_q        <= catch_d;
      lift_a_q       <= lift_a_d;
      lift_b_q       <= lift_b_d;
      end_q          <= end_d;
    end
  end

  // Load a result beat on accept, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  // Checks on the sequencer state and the result register
  `TAS_ASSERT_IMPL(a_wait_in_range, clk_i, rst_ni, wait_active_q,
                   (wait_elapsed_q < wait_length_q) || (wait_elapsed_q == '0),
                   "running wait passed its length")
  `TAS_ASSERT_IMPL(a_step_in_range, clk_i, rst_ni, 1'b1,
                   step_q <= SW'(tas_pkg::MaxSeqLen),
                   "step index past the longest sequence")
  `TAS_ASSERT_NEXT(a_accept_loads_out, clk_i, rst_ni, in_accept,
                   out_valid_q,
                   "accepted tick left no result beat")

endmodule
